// ===== src/cgr_pkg.sv =====
// Shared types and constants for the color gradient ramp.
package cgr_pkg;

	localparam int MaxStops = 16;
	localparam int IdxW = $clog2(MaxStops);
	localparam int CntW = $clog2(MaxStops + 1);

	typedef logic [IdxW-1:0] idx_t;
	typedef logic [CntW-1:0] cnt_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DUP   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_WR,
		S_Q_RD,
		S_Q_WAIT,
		S_Q_DIV,
		S_Q_MUL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] position;
		logic [31:0] color;
	} stop_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic        opcode;
		logic [15:0] position;
		logic [7:0]  stop_red;
		logic [7:0]  stop_green;
		logic [7:0]  stop_blue;
		logic [7:0]  stop_alpha;
	} item_t;

endpackage

// ===== src/cgr_if.sv =====
// Valid/ready channel interfaces for the color gradient ramp.
interface cgr_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] position;
	logic [7:0]  stop_red;
	logic [7:0]  stop_green;
	logic [7:0]  stop_blue;
	logic [7:0]  stop_alpha;
	modport source (output valid, opcode, position, stop_red, stop_green, stop_blue,
		stop_alpha, input ready);
	modport sink (input valid, opcode, position, stop_red, stop_green, stop_blue,
		stop_alpha, output ready);
endinterface

interface cgr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic [1:0] status;
	modport source (output valid, red, green, blue, alpha, status, input ready);
	modport sink (input valid, red, green, blue, alpha, status, output ready);
endinterface

// ===== src/cgr_ram.sv =====
// Stop table memory: one write port, one registered read port.
module cgr_ram (
	input  logic          clk,
	input  logic          we,
	input  cgr_pkg::idx_t waddr,
	input  cgr_pkg::stop_t wdata,
	input  cgr_pkg::idx_t raddr,
	output cgr_pkg::stop_t rdata
);
	cgr_pkg::stop_t mem [cgr_pkg::MaxStops];

	// Write and read in one clocked block
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/cgr_div.sv =====
// Restoring divider: 32-bit dividend by 17-bit divisor, one quotient bit a cycle.
module cgr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [16:0] den,
	output logic        busy,
	output logic [15:0] quo
);
	logic [5:0]  cnt_q;
	logic [31:0] num_q;
	logic [16:0] rem_q;
	logic [16:0] den_q;
	logic [15:0] quo_q;
	logic [17:0] trial;

	assign trial = {rem_q, num_q[31]} - {1'b0, den_q};
	assign busy = cnt_q != 6'd0;
	assign quo = quo_q;

	// Advance one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[30:0], 1'b0};
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], num_q[31]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end
endmodule

// ===== src/color_gradient_ramp.sv =====
// Top level of the color gradient ramp: sequencer around the stop table.
// One transaction at a time. The stops live in a 16-entry RAM read one entry
// a cycle through a registered read port. An insert scans for its place (a read
// state and a check state per stop visited), then shifts the tail up one entry at
// a time (a read state and a write state per entry moved), then writes the new
// stop; a duplicate or a full table ends it at the scan. A query scans to the
// bracketing stop, then starts the divider for the fraction, waits for it, and
// passes a read state and a blend state; a query at a stop or outside the stops
// returns that stop's color. A result waits in an output register; the next
// transaction is taken once it has been delivered.
module color_gradient_ramp (
	input logic     clk,
	input logic     arst_n,
	cgr_in_if.sink  in_ch,
	cgr_out_if.source out_ch
);
	cgr_pkg::state_t state_q, state_d;
	cgr_pkg::item_t  item_q;
	cgr_pkg::cnt_t   count_q, idx_q, ins_q;
	cgr_pkg::stop_t  prev_q, rdata, wdata;
	cgr_pkg::idx_t   raddr, waddr;
	cgr_pkg::result_t res_q;
	logic            we, out_valid_q;
	logic            div_start, div_busy;
	logic [15:0]     t_q, div_quo;
	logic [31:0]     div_num;
	logic [16:0]     div_den;
	logic signed [15:0] qpos, rpos, ppos;
	logic [31:0]     blend_c;

	assign qpos = item_q.position;
	assign rpos = rdata.position;
	assign ppos = prev_q.position;

	cgr_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr),
		.rdata(rdata));

	cgr_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quo(div_quo));

	assign div_num = {16'(qpos - ppos), 16'd0};
	assign div_den = 17'(signed'({rpos[15], rpos}) - signed'({ppos[15], ppos}));

	assign in_ch.ready = (state_q == cgr_pkg::S_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.red = res_q.red;
	assign out_ch.green = res_q.green;
	assign out_ch.blue = res_q.blue;
	assign out_ch.alpha = res_q.alpha;
	assign out_ch.status = res_q.status;

	// Blend the bracketing colors with the fraction
	always_comb begin
		logic [16:0] tc;
		logic [24:0] v;
		tc = 17'h10000 - {1'b0, t_q};
		blend_c = '0;
		for (int s = 0; s < 4; s++) begin
			v = ({17'd0, prev_q.color[8*s +: 8]} * {8'd0, tc})
				+ ({17'd0, rdata.color[8*s +: 8]} * {9'd0, t_q});
			blend_c[8*s +: 8] = v[23:16];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cgr_pkg::S_IDLE:
				if (in_ch.valid && in_ch.ready) begin
					if (in_ch.opcode == cgr_pkg::OP_QUERY)
						state_d = (count_q == '0) ? cgr_pkg::S_DONE : cgr_pkg::S_SCAN_RD;
					else
						state_d = (count_q == '0) ? cgr_pkg::S_INS_WR : cgr_pkg::S_SCAN_RD;
				end
			cgr_pkg::S_SCAN_RD: state_d = cgr_pkg::S_SCAN_CHK;
			cgr_pkg::S_SCAN_CHK:
				if (item_q.opcode == cgr_pkg::OP_INSERT) begin
					if (rpos == qpos) state_d = cgr_pkg::S_DONE;
					else if (rpos > qpos || idx_q == count_q - 1'b1) begin
						if (count_q == cgr_pkg::CntW'(cgr_pkg::MaxStops))
							state_d = cgr_pkg::S_DONE;
						else if (rpos > qpos) state_d = cgr_pkg::S_SHIFT_RD;
						else state_d = cgr_pkg::S_INS_WR;
					end else state_d = cgr_pkg::S_SCAN_RD;
				end else begin
					if (rpos >= qpos || idx_q == count_q - 1'b1) begin
						if (idx_q == '0 || rpos == qpos || rpos < qpos)
							state_d = cgr_pkg::S_DONE;
						else state_d = cgr_pkg::S_Q_DIV;
					end else state_d = cgr_pkg::S_SCAN_RD;
				end
			cgr_pkg::S_SHIFT_RD: state_d = cgr_pkg::S_SHIFT_WR;
			cgr_pkg::S_SHIFT_WR:
				state_d = (idx_q == ins_q + 1'b1) ? cgr_pkg::S_INS_WR : cgr_pkg::S_SHIFT_RD;
			cgr_pkg::S_INS_WR: state_d = cgr_pkg::S_DONE;
			cgr_pkg::S_Q_DIV: state_d = cgr_pkg::S_Q_WAIT;
			cgr_pkg::S_Q_WAIT: if (!div_busy) state_d = cgr_pkg::S_Q_RD;
			cgr_pkg::S_Q_RD: state_d = cgr_pkg::S_Q_MUL;
			cgr_pkg::S_Q_MUL: state_d = cgr_pkg::S_IDLE;
			cgr_pkg::S_DONE: state_d = cgr_pkg::S_IDLE;
			default: state_d = cgr_pkg::S_IDLE;
		endcase
	end

	// Memory access and divider control
	always_comb begin
		raddr = idx_q[cgr_pkg::IdxW-1:0];
		we = 1'b0;
		waddr = idx_q[cgr_pkg::IdxW-1:0];
		wdata = rdata;
		div_start = 1'b0;
		unique case (state_q)
			cgr_pkg::S_SHIFT_RD: raddr = cgr_pkg::IdxW'(idx_q - 1'b1);
			cgr_pkg::S_SHIFT_WR: we = 1'b1;
			cgr_pkg::S_INS_WR: begin
				we = 1'b1;
				wdata.position = item_q.position;
				wdata.color = {item_q.stop_alpha, item_q.stop_blue, item_q.stop_green,
					item_q.stop_red};
			end
			cgr_pkg::S_Q_DIV: div_start = 1'b1;
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cgr_pkg::S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				cgr_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) idx_q <= '0;
				cgr_pkg::S_SCAN_CHK:
					if (state_d == cgr_pkg::S_SCAN_RD) idx_q <= idx_q + 1'b1;
					else if (state_d == cgr_pkg::S_INS_WR) idx_q <= count_q;
					else if (state_d == cgr_pkg::S_SHIFT_RD) idx_q <= count_q;
				cgr_pkg::S_SHIFT_WR: idx_q <= idx_q - 1'b1;
				cgr_pkg::S_INS_WR: count_q <= count_q + 1'b1;
				default: ;
			endcase
			if (state_q == cgr_pkg::S_DONE || state_q == cgr_pkg::S_Q_MUL)
				out_valid_q <= 1'b1;
		end
	end

	// Shift stop: track the insertion index so the walk down ends there
	always_ff @(posedge clk) begin
		if (state_q == cgr_pkg::S_SCAN_CHK) ins_q <= idx_q;
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			item_q <= '{opcode: in_ch.opcode, position: in_ch.position,
				stop_red: in_ch.stop_red, stop_green: in_ch.stop_green,
				stop_blue: in_ch.stop_blue, stop_alpha: in_ch.stop_alpha};
		// hold the lower stop of the bracket while the scan moves on
		if (state_q == cgr_pkg::S_SCAN_CHK && state_d == cgr_pkg::S_SCAN_RD) prev_q <= rdata;
		if (state_q == cgr_pkg::S_Q_WAIT && !div_busy) t_q <= div_quo;
		if (state_q == cgr_pkg::S_IDLE && in_ch.valid && in_ch.ready) begin
			res_q <= '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF,
				status: cgr_pkg::ST_EMPTY};
		end
		if (state_q == cgr_pkg::S_SCAN_CHK) begin
			if (item_q.opcode == cgr_pkg::OP_INSERT)
				res_q <= '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0,
					status: (rpos == qpos) ? cgr_pkg::ST_DUP :
					(count_q == cgr_pkg::CntW'(cgr_pkg::MaxStops)) ? cgr_pkg::ST_FULL :
					cgr_pkg::ST_OK};
			else
				res_q <= '{red: rdata.color[7:0], green: rdata.color[15:8],
					blue: rdata.color[23:16], alpha: rdata.color[31:24],
					status: cgr_pkg::ST_OK};
		end
		if (state_q == cgr_pkg::S_INS_WR)
			res_q <= '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0,
				status: cgr_pkg::ST_OK};
		if (state_q == cgr_pkg::S_Q_MUL)
			res_q <= '{red: blend_c[7:0], green: blend_c[15:8], blue: blend_c[23:16],
				alpha: blend_c[31:24], status: cgr_pkg::ST_OK};
	end
endmodule

// ===== tb/color_gradient_ramp_test.sv =====
// Self-checking testbench for the color gradient ramp: directed table plus random traffic.
module color_gradient_ramp_test;

	typedef struct {
		cgr_pkg::opcode_t op;
		logic [15:0]      pos;
		logic [31:0]      color;
		logic             typed;
		cgr_pkg::result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	cgr_in_if  in_ch();
	cgr_out_if out_ch();

	color_gradient_ramp u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// predictor state
	logic signed [15:0] ramp_pos [cgr_pkg::MaxStops];
	logic [31:0]        ramp_col [cgr_pkg::MaxStops];
	int                 ramp_count;
	cgr_pkg::result_t   pending_colors [$];
	int                 errors;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	stim_row_t          table_rows [$];

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// blend two RGBA colors by a 16-bit fraction
	function automatic logic [31:0] mix_colors(logic [31:0] c1, logic [31:0] c2,
		logic [31:0] t);
		logic [31:0] r;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] v;
		r = '0;
		for (int s = 0; s < 32; s += 8) begin
			a = (c1 >> s) & 32'hFF;
			b = (c2 >> s) & 32'hFF;
			v = (a * (32'd65536 - t) + b * t) >> 16;
			r |= (v & 32'hFF) << s;
		end
		return r;
	endfunction

	// compute the expected result and update the stop table
	function automatic cgr_pkg::result_t ramp_lookup(cgr_pkg::opcode_t op,
		logic signed [15:0] pos, logic [31:0] color);
		cgr_pkg::result_t res;
		logic [31:0] c;
		logic [31:0] num;
		logic [31:0] den;
		logic [31:0] t;
		int i;
		int p1;
		int p2;
		res = '0;
		if (op == cgr_pkg::OP_INSERT) begin
			for (i = 0; i < ramp_count; i++) begin
				if (ramp_pos[i] == pos) begin
					res.status = cgr_pkg::ST_DUP;
					return res;
				end
				if (ramp_pos[i] > pos) break;
			end
			if (ramp_count >= cgr_pkg::MaxStops) begin
				res.status = cgr_pkg::ST_FULL;
				return res;
			end
			for (int k = ramp_count; k > i; k--) begin
				ramp_pos[k] = ramp_pos[k-1];
				ramp_col[k] = ramp_col[k-1];
			end
			ramp_pos[i] = pos;
			ramp_col[i] = color;
			ramp_count++;
			res.status = cgr_pkg::ST_OK;
			return res;
		end
		if (ramp_count == 0) begin
			res = {8'hFF, 8'hFF, 8'hFF, 8'hFF, cgr_pkg::ST_EMPTY};
			return res;
		end
		if (pos < ramp_pos[0]) c = ramp_col[0];
		else if (pos > ramp_pos[ramp_count-1]) c = ramp_col[ramp_count-1];
		else begin
			for (i = 0; i < ramp_count - 1; i++)
				if (ramp_pos[i] >= pos) break;
			if (i == 0 || ramp_pos[i] == pos) c = ramp_col[i];
			else begin
				p1 = ramp_pos[i-1];
				p2 = ramp_pos[i];
				num = 32'(int'(pos) - p1) << 16;
				den = 32'(p2 - p1);
				t = (den != 0) ? (num / den) & 32'hFFFF : 32'd0;
				c = mix_colors(ramp_col[i-1], ramp_col[i], t);
			end
		end
		res.red = c[7:0];
		res.green = c[15:8];
		res.blue = c[23:16];
		res.alpha = c[31:24];
		res.status = cgr_pkg::ST_OK;
		return res;
	endfunction

	// drive one transaction and queue its expected result
	task automatic send_item(cgr_pkg::opcode_t op, logic [15:0] pos, logic [31:0] color,
		logic typed, cgr_pkg::result_t typed_res);
		cgr_pkg::result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.position <= pos;
		in_ch.stop_red <= color[7:0];
		in_ch.stop_green <= color[15:8];
		in_ch.stop_blue <= color[23:16];
		in_ch.stop_alpha <= color[31:24];
		do @(posedge clk); while (!in_ch.ready);
		res = ramp_lookup(op, pos, color);
		pending_colors.push_back(typed ? typed_res : res);
	endtask

	// random position: mostly one of four small windows so stops collide and bracket queries
	function automatic logic [15:0] pick_pos();
		case ($urandom_range(3))
			0: return 16'($urandom);
			default: return 16'($urandom_range(40)) - 16'd20 + 16'(($urandom_range(3)) << 12);
		endcase
	endfunction

	// check each delivered result against the oldest expectation
	always @(posedge clk) begin
		cgr_pkg::result_t got;
		cgr_pkg::result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha, out_ch.status};
			if (pending_colors.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_colors.pop_front();
				if (got != want) begin
					$display("%0t mismatch: expected r%h g%h b%h a%h s%0d, ", $time,
						want.red, want.green, want.blue, want.alpha, want.status,
						"got r%h g%h b%h a%h s%0d",
						got.red, got.green, got.blue, got.alpha, got.status);
					errors++;
				end
			end
		end
	end

	// random receiver stall
	always @(posedge clk) begin
		if (!arst_n) out_ch.ready <= 1'b0;
		else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	initial begin
		#40000000;
		$display("color_gradient_ramp_test failed");
		$finish;
	end

	initial begin
		stim_row_t        row;
		cgr_pkg::result_t dummy;
		int               phase;
		errors = 0;
		ramp_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		dummy = '0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = cgr_pkg::OP_INSERT;
		in_ch.position = '0;
		in_ch.stop_red = '0;
		in_ch.stop_green = '0;
		in_ch.stop_blue = '0;
		in_ch.stop_alpha = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: empty query, extremes, duplicates, full table, exact hits
		table_rows.push_back('{cgr_pkg::OP_QUERY, 16'h1234, 32'h0, 1'b1,
			{32'hFFFFFFFF, cgr_pkg::ST_EMPTY}});
		table_rows.push_back('{cgr_pkg::OP_INSERT, 16'h8000, 32'h00000000, 1'b1,
			{32'h0, cgr_pkg::ST_OK}});
		table_rows.push_back('{cgr_pkg::OP_INSERT, 16'h7FFF, 32'hFFFFFFFF, 1'b1,
			{32'h0, cgr_pkg::ST_OK}});
		table_rows.push_back('{cgr_pkg::OP_INSERT, 16'h7FFF, 32'h12345678, 1'b1,
			{32'h0, cgr_pkg::ST_DUP}});
		table_rows.push_back('{cgr_pkg::OP_QUERY, 16'h8000, 32'h0, 1'b1,
			{32'h0, cgr_pkg::ST_OK}});
		table_rows.push_back('{cgr_pkg::OP_QUERY, 16'h7FFF, 32'h0, 1'b1,
			{32'hFFFFFFFF, cgr_pkg::ST_OK}});
		table_rows.push_back('{cgr_pkg::OP_QUERY, 16'h0000, 32'h0, 1'b0, dummy});
		table_rows.push_back('{cgr_pkg::OP_QUERY, 16'h7FFE, 32'h0, 1'b0, dummy});
		table_rows.push_back('{cgr_pkg::OP_QUERY, 16'h8001, 32'h0, 1'b0, dummy});
		for (int k = 0; k < 14; k++)
			table_rows.push_back('{cgr_pkg::OP_INSERT, 16'(k * 256 - 1700),
				{8'(k * 17), 8'(255 - k), 8'(k * 40), 8'hA5 ^ 8'(k)}, 1'b0, dummy});
		table_rows.push_back('{cgr_pkg::OP_INSERT, 16'h0100, 32'hDEADBEEF, 1'b1,
			{32'h0, cgr_pkg::ST_FULL}});
		table_rows.push_back('{cgr_pkg::OP_INSERT, 16'hF95C, 32'hDEADBEEF, 1'b1,
			{32'h0, cgr_pkg::ST_DUP}});
		table_rows.push_back('{cgr_pkg::OP_QUERY, 16'h0080, 32'h0, 1'b0, dummy});
		foreach (table_rows[i]) begin
			row = table_rows[i];
			send_item(row.op, row.pos, row.color, row.typed, row.res);
		end

		// random phases with different sender idle and receiver stall mixes
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int n = 0; n < 225; n++) begin
				if ($urandom_range(99) < 35)
					send_item(cgr_pkg::OP_INSERT, pick_pos(), $urandom, 1'b0, dummy);
				else
					send_item(cgr_pkg::OP_QUERY, pick_pos(), $urandom, 1'b0, dummy);
				if (n == 100) begin
					// hold the sender until the ramp has drained
					in_ch.valid <= 1'b0;
					while (pending_colors.size() != 0) @(posedge clk);
				end
			end
		end
		in_ch.valid <= 1'b0;

		// drain and let the block settle
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("color_gradient_ramp_test passed");
		else
			$display("color_gradient_ramp_test failed");
		$finish;
	end
endmodule

// ===== color_gradient_ramp.f =====
src/cgr_pkg.sv
src/cgr_if.sv
src/cgr_ram.sv
src/cgr_div.sv
src/color_gradient_ramp.sv
tb/color_gradient_ramp_test.sv
